// ----- sv/sdcf_pkg.sv -----
// Shared types, constants and the CRC7 byte step for the SD SPI command framer.
package sdcf_pkg;

    localparam int unsigned BEAT_W = 3;

    localparam logic [7:0] CMD_START_BITS  = 8'h40;
    localparam logic [6:0] CRC_POLY        = 7'h09;
    localparam logic [7:0] IDLE_BYTE       = 8'hFF;
    localparam logic [7:0] MAX_POLLS_RESET = 8'd129;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_RX    = 1'b1;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [BEAT_W-1:0] BEAT_DUMMY = 3'd0;
    localparam logic [BEAT_W-1:0] BEAT_CMD   = 3'd1;
    localparam logic [BEAT_W-1:0] BEAT_ARG3  = 3'd2;
    localparam logic [BEAT_W-1:0] BEAT_ARG2  = 3'd3;
    localparam logic [BEAT_W-1:0] BEAT_ARG1  = 3'd4;
    localparam logic [BEAT_W-1:0] BEAT_ARG0  = 3'd5;
    localparam logic [BEAT_W-1:0] BEAT_CRC   = 3'd6;
    localparam logic [BEAT_W-1:0] BEAT_POLL  = 3'd7;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] tx_byte;
        logic [7:0] response;
        logic       timed_out;
        logic       last;
    } result_t;

    typedef struct packed {
        logic consume;
        logic res_valid;
        logic awaiting;
    } core_ctl_t;

    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int b = 7; b >= 0; b--)
        begin
            fb  = data[b] ^ crc[6];
            crc = {crc[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'h00);
        end
        return crc;
    endfunction

endpackage

// ----- sv/sdcf_core.sv -----
// Command sequencer: frame bytes with running CRC7, then response polling.
module sdcf_core
    import sdcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  item_t     item,
    input  logic [7:0] max_polls,
    input  logic      out_free,
    output core_ctl_t ctl,
    output result_t   res
);

    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic [6:0]        crc_reg, crc_next;
    logic              awaiting_reg, awaiting_next;
    logic [7:0]        poll_count_reg, poll_count_next;

    logic       is_start;
    logic       ignore;
    logic [7:0] frame_byte;

    assign is_start = (item.req_type == REQ_START);
    assign ignore   = is_start ? awaiting_reg : !awaiting_reg;

    always_comb
    begin
        case (beat_reg)
            BEAT_DUMMY: frame_byte = IDLE_BYTE;
            BEAT_CMD:   frame_byte = CMD_START_BITS | {2'b00, item.cmd_index};
            BEAT_ARG3:  frame_byte = item.argument[31:24];
            BEAT_ARG2:  frame_byte = item.argument[23:16];
            BEAT_ARG1:  frame_byte = item.argument[15:8];
            BEAT_ARG0:  frame_byte = item.argument[7:0];
            BEAT_CRC:   frame_byte = {crc_reg, 1'b1};
            BEAT_POLL:  frame_byte = IDLE_BYTE;
            default:    frame_byte = IDLE_BYTE;
        endcase
    end

    always_comb
    begin
        ctl.consume     = 1'b0;
        ctl.res_valid   = 1'b0;
        ctl.awaiting    = awaiting_reg;
        res             = '0;
        beat_next       = beat_reg;
        crc_next        = crc_reg;
        awaiting_next   = awaiting_reg;
        poll_count_next = poll_count_reg;

        if (item_valid && ignore)
        begin
            ctl.consume = 1'b1;
        end
        else if (item_valid && out_free)
        begin
            ctl.res_valid = 1'b1;
            if (is_start)
            begin
                res.result_kind = KIND_TX;
                res.tx_byte     = frame_byte;
                res.last        = (beat_reg == BEAT_POLL);
                beat_next       = beat_reg + 1'b1;
                if (beat_reg == BEAT_DUMMY)
                begin
                    crc_next = '0;
                end
                else if (beat_reg != BEAT_CRC && beat_reg != BEAT_POLL)
                begin
                    crc_next = crc7_byte(crc_reg, frame_byte);
                end
                if (beat_reg == BEAT_POLL)
                begin
                    ctl.consume     = 1'b1;
                    awaiting_next   = 1'b1;
                    poll_count_next = 8'd1;
                end
            end
            else
            begin
                ctl.consume = 1'b1;
                res.last    = 1'b1;
                if (item.rx_byte != IDLE_BYTE)
                begin
                    res.result_kind = KIND_DONE;
                    res.response    = item.rx_byte;
                    awaiting_next   = 1'b0;
                    poll_count_next = '0;
                end
                else if (poll_count_reg >= max_polls)
                begin
                    res.result_kind = KIND_DONE;
                    res.response    = IDLE_BYTE;
                    res.timed_out   = 1'b1;
                    awaiting_next   = 1'b0;
                    poll_count_next = '0;
                end
                else
                begin
                    res.result_kind = KIND_TX;
                    res.tx_byte     = IDLE_BYTE;
                    poll_count_next = poll_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg       <= BEAT_DUMMY;
            crc_reg        <= '0;
            awaiting_reg   <= 1'b0;
            poll_count_reg <= '0;
        end
        else
        begin
            beat_reg       <= beat_next;
            crc_reg        <= crc_next;
            awaiting_reg   <= awaiting_next;
            poll_count_reg <= poll_count_next;
        end
    end

endmodule

// ----- sv/sd_spi_command_framer.sv -----
// Top level of the SD SPI-mode command framer with input and result registers.
// A start command yields eight result transfers if idle, one per cycle while output is taken.
// A received byte yields one result transfer, registered in the result register.
// Input and result registers lie between ports; one result per cycle while output is taken.
// The next input transfer is taken while the final result of the previous item waits.
// Reset returns the core to idle, clears the poll count and loads max_polls with 129.
module sd_spi_command_framer
    import sdcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd_index[5:0], argument[37:6], rx_byte[45:38], zeros
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // tx_byte[7:0], response[15:8], timed_out[16], zeros
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic [7:0] max_polls_reg;

    logic      out_free;
    core_ctl_t ctl;
    result_t   res;

    assign s_axis_tready = !in_valid_reg || ctl.consume;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    sdcf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .max_polls  (max_polls_reg),
        .out_free   (out_free),
        .ctl        (ctl),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_polls_reg <= MAX_POLLS_RESET;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (ctl.consume)
            begin
                in_valid_reg <= 1'b0;
            end

            if (ctl.res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                max_polls_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.req_type  <= s_axis_tuser;
            in_item_reg.cmd_index <= s_axis_tdata[5:0];
            in_item_reg.argument  <= s_axis_tdata[37:6];
            in_item_reg.rx_byte   <= s_axis_tdata[45:38];
        end
        if (ctl.res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.result_kind;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {7'b0, out_res_reg.timed_out, out_res_reg.response,
                            out_res_reg.tx_byte};

`ifndef NO_ASSERTIONS
    // A waiting result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !ctl.res_valid)
        else $error("result register overwritten while stalled");

    // The core only waits for a response after the last byte of a command frame went out.
    a_await_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctl.awaiting ##1 ctl.awaiting) |->
            $past(ctl.res_valid && res.last && res.result_kind == KIND_TX))
        else $error("response wait entered without a completed frame");

    // A finished result always returns the core to idle.
    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.res_valid && res.result_kind == KIND_DONE) |=> !ctl.awaiting)
        else $error("core still waiting after a finished result");

    // An input item leaves the input register only in a cycle that consumes it.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !ctl.consume) |=> in_valid_reg)
        else $error("input item dropped before it was processed");
`endif

endmodule
